>>> rtl/overdrive_soft_clip_tone_core_macros.svh
// ---------------------------------------------------------------------------
// overdrive soft clip tone core assertion macros
// concurrent check wrappers, compiled out when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef OVERDRIVE_SOFT_CLIP_TONE_CORE_MACROS_SVH
`define OVERDRIVE_SOFT_CLIP_TONE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define OSCT_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define OSCT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OSCT_ASSERT_IMPLY(label, ck, rn, ante, cons, msg)
`define OSCT_ASSERT_NEXT(label, ck, rn, ante, cons, msg)
`endif
`endif

>>> rtl/osct_pkg.sv
// ---------------------------------------------------------------------------
// osct_pkg
// widths, constants, register indexes and controller types
// ---------------------------------------------------------------------------
`default_nettype none

package osct_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = 20;
    localparam int PROD_W    = 40;
    localparam int CNT_W     = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 2'd2;

    // settings in q1.15
    localparam logic [CFG_W-1:0] CFG_ONE   = 16'd32768;
    localparam logic [CFG_W-1:0] DRIVE_RST = 16'd16384;
    localparam logic [CFG_W-1:0] TONE_RST  = 16'd22938;
    localparam logic [CFG_W-1:0] LEVEL_RST = 16'd26214;

    localparam logic signed [SAMPLE_W-1:0] CLIP_LEVEL  = 16'sd24956;
    localparam logic signed [MUL_W-1:0]    ALPHA_SLOPE = 20'sd16056;
    localparam logic [CFG_W-1:0]           ALPHA_BASE  = 16'd16384;
    localparam logic signed [PROD_W-1:0]   RND_HALF    = 40'sd16384;
    localparam logic signed [PROD_W-1:0]   ONE_Q30     = 40'sd1073741824;
    localparam logic signed [PROD_W-1:0]   NEG_ONE_Q30 = -40'sd1073741824;
    // 27.0 in q30
    localparam logic [34:0]                TANH_K      = 35'd28991029248;

    // quotient bits produced by the divider, msb first
    localparam logic [CNT_W-1:0] DIV_LAST_BIT = 4'd14;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GAIN, ST_CLIP, ST_SQ, ST_DEN, ST_NLO, ST_NHI, ST_SUM, ST_RND,
        ST_DIV, ST_SIGN, ST_ALPHA, ST_MA, ST_MC, ST_MB, ST_FILT, ST_LVL, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_GAIN, OP_CLIP, OP_SQ, OP_DEN, OP_NLO, OP_NHI, OP_SUM,
        OP_RND, OP_DIV, OP_SIGN, OP_ALPHA, OP_MA, OP_MC, OP_MB, OP_FILT, OP_LVL,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clip;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/osct_in_if.sv
// ---------------------------------------------------------------------------
// osct_in_if
// dry sample channel, valid/ready with one signed sample per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface osct_in_if import osct_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/osct_out_if.sv
// ---------------------------------------------------------------------------
// osct_out_if
// wet sample channel, valid/ready with one signed sample per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface osct_out_if import osct_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/osct_ctrl.sv
// ---------------------------------------------------------------------------
// osct_ctrl
// sequencer for the shared multiplier, divider and output beat
// ---------------------------------------------------------------------------
`default_nettype none

module osct_ctrl import osct_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t stat,
    output cmd_t         cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                cmd.op     = OP_CLIP;
                state_next = stat.clip ? ST_ALPHA : ST_SQ;
            end
            ST_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                cmd.op     = OP_DEN;
                state_next = ST_NLO;
            end
            ST_NLO:
            begin
                cmd.op     = OP_NLO;
                state_next = ST_NHI;
            end
            ST_NHI:
            begin
                cmd.op     = OP_NHI;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.op     = OP_RND;
                cnt_next   = DIV_LAST_BIT;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                cmd.op     = OP_SIGN;
                state_next = ST_ALPHA;
            end
            ST_ALPHA:
            begin
                cmd.op     = OP_ALPHA;
                state_next = ST_MA;
            end
            ST_MA:
            begin
                cmd.op     = OP_MA;
                state_next = ST_MC;
            end
            ST_MC:
            begin
                cmd.op     = OP_MC;
                state_next = ST_MB;
            end
            ST_MB:
            begin
                cmd.op     = OP_MB;
                state_next = ST_FILT;
            end
            ST_FILT:
            begin
                cmd.op     = OP_FILT;
                state_next = ST_LVL;
            end
            ST_LVL:
            begin
                cmd.op     = OP_LVL;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/osct_dp.sv
// ---------------------------------------------------------------------------
// osct_dp
// settings, shared multiplier, restoring divider and filter state
// ---------------------------------------------------------------------------
`default_nettype none

module osct_dp import osct_pkg::*; (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cmd_t                       cmd,
    output status_t                         stat,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_wr_data,
    input  wire logic signed [SAMPLE_W-1:0] in_sample,
    output logic signed [SAMPLE_W-1:0]      out_sample
);

    // settings and filter state
    logic [CFG_W-1:0]           drive_reg, tone_reg, level_reg;
    logic [CFG_W-1:0]           drive_next, tone_next, level_next, cfg_clamped;
    logic signed [SAMPLE_W-1:0] lf_reg, lf_next;

    // working registers
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [16:0]         v_reg, v_next;
    logic [15:0]                vmag_reg, vmag_next;
    logic                       neg_reg, neg_next;
    logic [34:0]                a_reg, a_next;
    logic [35:0]                den_reg, den_next;
    logic [33:0]                lo_reg, lo_next;
    logic [50:0]                rem_reg, rem_next;
    logic [50:0]                dsh_reg, dsh_next;
    logic [14:0]                q_reg, q_next;
    logic signed [SAMPLE_W-1:0] c_reg, c_next;
    logic [CFG_W-1:0]           alpha_reg, alpha_next;
    logic signed [PROD_W-1:0]   t_reg, t_next;
    logic signed [SAMPLE_W-1:0] out_reg, out_next;

    // shared multiplier
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [MUL_W-1:0]           gain;
    logic [CFG_W-1:0]           alpha_comp;

    logic signed [PROD_W-1:0]   prod_rnd, filt_sum;
    logic signed [16:0]         v_neg;
    logic [30:0]                v2;
    logic [51:0]                diff;
    logic                       over, under;

    assign cfg_clamped = (cfg_wr_data > CFG_ONE) ? CFG_ONE : cfg_wr_data;
    // gain 1 + 9*drive in q5.15
    assign gain = MUL_W'(CFG_ONE) + {1'b0, drive_reg, 3'b000} + {4'b0000, drive_reg};
    assign alpha_comp = CFG_ONE - alpha_reg;
    assign mul_p = mul_a * mul_b;

    assign prod_rnd = prod_reg + RND_HALF;
    assign filt_sum = t_reg + prod_reg + RND_HALF;
    assign over     = prod_reg > ONE_Q30;
    assign under    = prod_reg < NEG_ONE_Q30;
    assign v_neg    = -v_reg;
    assign v2       = prod_reg[30:0];
    assign diff     = {1'b0, rem_reg} - {1'b0, dsh_reg};

    assign stat.clip = over || under;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_GAIN:
            begin
                mul_a = {{(MUL_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
                mul_b = gain;
            end
            OP_SQ:
            begin
                mul_a = {{3{v_reg[16]}}, v_reg};
                mul_b = {{3{v_reg[16]}}, v_reg};
            end
            OP_NLO:
            begin
                mul_a = {4'b0000, vmag_reg};
                mul_b = {2'b00, a_reg[17:0]};
            end
            OP_NHI:
            begin
                mul_a = {4'b0000, vmag_reg};
                mul_b = {3'b000, a_reg[34:18]};
            end
            OP_ALPHA:
            begin
                mul_a = {4'b0000, tone_reg};
                mul_b = ALPHA_SLOPE;
            end
            OP_MC:
            begin
                mul_a = {4'b0000, alpha_reg};
                mul_b = {{(MUL_W-SAMPLE_W){c_reg[SAMPLE_W-1]}}, c_reg};
            end
            OP_MB:
            begin
                mul_a = {4'b0000, alpha_comp};
                mul_b = {{(MUL_W-SAMPLE_W){lf_reg[SAMPLE_W-1]}}, lf_reg};
            end
            OP_LVL:
            begin
                mul_a = {{(MUL_W-SAMPLE_W){lf_reg[SAMPLE_W-1]}}, lf_reg};
                mul_b = {4'b0000, level_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        x_next     = x_reg;
        prod_next  = prod_reg;
        v_next     = v_reg;
        vmag_next  = vmag_reg;
        neg_next   = neg_reg;
        a_next     = a_reg;
        den_next   = den_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        c_next     = c_reg;
        alpha_next = alpha_reg;
        t_next     = t_reg;
        out_next   = out_reg;
        lf_next    = lf_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                x_next = in_sample;
            end
            OP_GAIN, OP_SQ, OP_NLO, OP_ALPHA, OP_MC, OP_LVL:
            begin
                prod_next = mul_p;
            end
            OP_CLIP:
            begin
                // hard step to the clip level only strictly beyond unity
                if (over)
                begin
                    c_next = CLIP_LEVEL;
                end
                else if (under)
                begin
                    c_next = -CLIP_LEVEL;
                end
                v_next = prod_rnd[31:15];
            end
            OP_DEN:
            begin
                neg_next  = v_reg[16];
                vmag_next = v_reg[16] ? v_neg[15:0] : v_reg[15:0];
                a_next    = TANH_K + {4'b0000, v2};
                den_next  = {1'b0, TANH_K} + {2'b00, v2, 3'b000} + {5'b00000, v2};
            end
            OP_NHI:
            begin
                lo_next   = prod_reg[33:0];
                prod_next = mul_p;
            end
            OP_SUM:
            begin
                rem_next = {prod_reg[32:0], 18'b0} + {17'b0, lo_reg};
            end
            OP_RND:
            begin
                // round to nearest by adding half the divisor
                rem_next = rem_reg + {16'b0, den_reg[35:1]};
                dsh_next = {1'b0, den_reg, 14'b0};
                q_next   = '0;
            end
            OP_DIV:
            begin
                if (!diff[51])
                begin
                    rem_next = diff[50:0];
                end
                q_next   = {q_reg[13:0], ~diff[51]};
                dsh_next = dsh_reg >> 1;
            end
            OP_SIGN:
            begin
                c_next = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
            end
            OP_MA:
            begin
                alpha_next = ALPHA_BASE + {2'b00, prod_rnd[28:15]};
            end
            OP_MB:
            begin
                t_next    = prod_reg;
                prod_next = mul_p;
            end
            OP_FILT:
            begin
                lf_next = filt_sum[30:15];
            end
            OP_OUT:
            begin
                out_next = prod_rnd[30:15];
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= DRIVE_RST;
            tone_reg  <= TONE_RST;
            level_reg <= LEVEL_RST;
            lf_reg    <= '0;
        end
        else
        begin
            drive_reg <= drive_next;
            tone_reg  <= tone_next;
            level_reg <= level_next;
            lf_reg    <= lf_next;
        end
    end

    always_comb
    begin
        drive_next = drive_reg;
        tone_next  = tone_reg;
        level_next = level_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DRIVE: drive_next = cfg_clamped;
                REG_TONE:  tone_next  = cfg_clamped;
                REG_LEVEL: level_next = cfg_clamped;
                default:   drive_next = drive_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        prod_reg  <= prod_next;
        v_reg     <= v_next;
        vmag_reg  <= vmag_next;
        neg_reg   <= neg_next;
        a_reg     <= a_next;
        den_reg   <= den_next;
        lo_reg    <= lo_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        q_reg     <= q_next;
        c_reg     <= c_next;
        alpha_reg <= alpha_next;
        t_reg     <= t_next;
        out_reg   <= out_next;
    end

    assign out_sample = out_reg;

endmodule

`default_nettype wire

>>> rtl/overdrive_soft_clip_tone_core.sv
// one beat is processed at a time: a new beat is taken only after the last result has moved to
// the output register; a clipped sample skips the tanh curve and the 15-step restoring divider,
//   and every sample walks the sequencer through the one shared 20x20 multiplier
// a finished result waits in the output register while the next beat is taken
// reset: async active low, clears the filter state and restores the setting defaults
// ---------------------------------------------------------------------------
// overdrive_soft_clip_tone_core
// soft clip overdrive with rational tanh curve, one-pole tone filter and level
// ---------------------------------------------------------------------------
`default_nettype none

`include "overdrive_soft_clip_tone_core_macros.svh"

module overdrive_soft_clip_tone_core import osct_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    osct_in_if.sink                   dry,
    osct_out_if.source                wet,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t stat;

    logic    in_ready;
    logic    out_valid;
    logic signed [SAMPLE_W-1:0] out_sample;

    // sequencer: owns the handshakes and the divider step count
    osct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dry.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (wet.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: settings, multiplier, divider, filter state, output register
    osct_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_sample   (dry.in_sample),
        .out_sample  (out_sample)
    );

    assign dry.ready      = in_ready;
    assign wet.valid      = out_valid;
    assign wet.out_sample = out_sample;

    // an accepted beat is latched and its gain multiply starts right after
    `OSCT_ASSERT_IMPLY(a_accept_loads, clk, rst_n, dry.valid && dry.ready, cmd.op == OP_LOAD, "accepted beat not latched")
    `OSCT_ASSERT_NEXT(a_accept_gain, clk, rst_n, dry.valid && dry.ready, cmd.op == OP_GAIN && !dry.ready, "gain step does not follow accept")
    // a finished sample always shows up on the output channel
    `OSCT_ASSERT_NEXT(a_out_valid, clk, rst_n, cmd.op == OP_OUT, wet.valid, "result not presented")

endmodule

`default_nettype wire

>>> test/overdrive_soft_clip_tone_core_tb.sv
// ---------------------------------------------------------------------------
// overdrive_soft_clip_tone_core_tb
// self-checking bench for the soft clip overdrive core: dry samples go in
// through a queue-fed driver, every wet beat is checked against a bit-true
// model of the gain, clip/tanh curve, one-pole tone filter and level stage
// ---------------------------------------------------------------------------
`default_nettype none

module overdrive_soft_clip_tone_core_tb;
    import osct_pkg::*;

    // unused register slot, writes there must leave every setting alone
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint TANH_27    = 27 * Q30_ONE;
    localparam longint HALF_LSB   = 64'sd16384;
    localparam int     STALL_MAX  = 4000;
    localparam int     RAND_SETS  = 16;
    localparam int     SET_BEATS  = 118;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // testbench-side drivers, known from time zero
    logic                       dry_valid   = 1'b0;
    logic signed [SAMPLE_W-1:0] dry_sample  = '0;
    logic                       wet_ready   = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [CFG_W-1:0]           cfg_wr_data = '0;

    osct_in_if  dry ();
    osct_out_if wet ();

    assign dry.valid     = dry_valid;
    assign dry.in_sample = dry_sample;
    assign wet.ready     = wet_ready;

    overdrive_soft_clip_tone_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .dry         (dry),
        .wet         (wet),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // model copy of the settings and the filter memory
    logic [CFG_W-1:0]           drive_set = DRIVE_RST;
    logic [CFG_W-1:0]           tone_set  = TONE_RST;
    logic [CFG_W-1:0]           level_set = LEVEL_RST;
    logic signed [SAMPLE_W-1:0] tone_mem  = '0;

    logic signed [SAMPLE_W-1:0] dry_q[$];     // samples waiting to be sent
    logic signed [SAMPLE_W-1:0] wet_expect_q[$];

    bit steady = 1'b0;                         // no gaps on either side
    int errors = 0;
    int sent_beats = 0;
    int checked_beats = 0;
    int clipped_beats = 0;
    int unity_hits = 0;
    int setting_sets = 0;
    int quiet_cycles = 0;

    // 8 time unit period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // bit-true model of one beat, advances the filter memory
    function automatic logic signed [SAMPLE_W-1:0] shape_sample(
        input logic signed [SAMPLE_W-1:0] x);
        longint gain, driven, v, v2, num, den, mag, q, c, alpha, acc, filt, y;
        gain   = 64'sd32768 + 9 * longint'(drive_set);
        driven = longint'(x) * gain;
        if (driven > Q30_ONE)
        begin
            c = longint'(CLIP_LEVEL);
            clipped_beats++;
        end
        else if (driven < -Q30_ONE)
        begin
            c = -longint'(CLIP_LEVEL);
            clipped_beats++;
        end
        else
        begin
            // exactly +-1 after drive stays on the rational curve
            if (driven == Q30_ONE || driven == -Q30_ONE)
                unity_hits++;
            v   = (driven + HALF_LSB) >>> 15;
            v2  = v * v;
            num = v * (TANH_27 + v2);
            den = TANH_27 + 9 * v2;
            mag = (num < 0) ? -num : num;
            q   = (mag + den / 2) / den;      // nearest, ties away from zero
            c   = (num < 0) ? -q : q;
        end
        // one-pole tone filter, alpha in 0.5 .. 0.99
        alpha = 64'sd16384 + ((longint'(tone_set) * 64'sd16056 + HALF_LSB) >>> 15);
        acc   = alpha * c + (64'sd32768 - alpha) * longint'(tone_mem);
        filt  = (acc + HALF_LSB) >>> 15;
        tone_mem = filt[SAMPLE_W-1:0];
        y = (filt * longint'(level_set) + HALF_LSB) >>> 15;
        return y[SAMPLE_W-1:0];
    endfunction

    // driver: predicts on every accepted beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_valid  <= 1'b0;
            dry_sample <= '0;
        end
        else
        begin
            if (dry_valid && dry.ready)
            begin
                wet_expect_q.push_back(shape_sample(dry_sample));
                sent_beats++;
            end
            if (!dry_valid || dry.ready)
            begin
                if (dry_q.size() != 0 && (steady || $urandom_range(99) >= 8))
                begin
                    dry_valid  <= 1'b1;
                    dry_sample <= dry_q.pop_front();
                end
                else
                    dry_valid <= 1'b0;
            end
        end
    end

    // monitor: checks wet beats in order, random backpressure, stall watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wet_ready <= 1'b0;
        else
        begin
            if (wet.valid && wet_ready)
            begin
                if (wet_expect_q.size() == 0)
                begin
                    $error("out_sample: no beat expected, got %0d", wet.out_sample);
                    errors++;
                end
                else
                begin
                    if (wet.out_sample !== wet_expect_q[0])
                    begin
                        $error("out_sample mismatch: expected %0d, got %0d",
                               wet_expect_q[0], wet.out_sample);
                        errors++;
                    end
                    void'(wet_expect_q.pop_front());
                    checked_beats++;
                end
            end
            wet_ready <= steady || ($urandom_range(99) >= 8);

            if ((dry_valid && dry.ready) || (wet.valid && wet_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("timeout: no beat moved for %0d cycles", STALL_MAX);
                $display("overdrive_soft_clip_tone_core_tb: done, errors");
                $finish;
            end
        end
    end

    // register write; model follows, values above 1.0 clamp, spare slot ignored
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] val);
        logic [CFG_W-1:0] eff;
        eff = (val > CFG_ONE) ? CFG_ONE : val;
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DRIVE: drive_set = eff;
            REG_TONE:  tone_set  = eff;
            REG_LEVEL: level_set = eff;
            default:   ;
        endcase
        setting_sets++;
    endtask

    // block until every queued beat went in and every result came back
    task automatic drain();
        while (dry_q.size() != 0 || dry_valid || wet_expect_q.size() != 0)
            @(posedge clk);
        // each beat yields a result, so the core is idle here; small margin
        repeat (4) @(posedge clk);
    endtask

    task automatic send(input logic signed [SAMPLE_W-1:0] s);
        dry_q.push_back(s);
    endtask

    // settings mix: both ends, over-range values that clamp, anything between
    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CFG_ONE;
            2:       return CFG_W'($urandom_range(65535, 32769));
            default: return CFG_W'($urandom_range(32768, 0));
        endcase
    endfunction

    // sample mix aimed at the clip threshold for the current drive
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int gain, knee, s;
        gain = 32768 + 9 * int'(drive_set);
        knee = 1073741824 / gain;
        case ($urandom_range(9))
            0, 1, 2, 3: s = int'($urandom_range(65535)) - 32768;
            4, 5:       s = $urandom_range(knee, 0);
            6, 7:       s = knee + int'($urandom_range(4)) - 2;
            8:          s = int'($urandom_range(511)) - 256;
            default:    s = ($urandom_range(1) != 0) ? 32767 : -32768;
        endcase
        if ($urandom_range(1) != 0)
            s = -s;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s[SAMPLE_W-1:0];
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: zero, both rails, plus and minus one, alternating bit patterns
        send(16'sd0);
        send(16'sd32767);
        send(-16'sd32768);
        send(16'sd1);
        send(-16'sd1);
        send(16'sh5555);
        send(16'shAAAA);
        drain();

        // no drive: a full negative rail lands exactly on -1.0 and is not clipped
        write_setting(REG_DRIVE, '0);
        send(-16'sd32768);
        send(16'sd32767);
        drain();

        // over-range drive clamps to max gain, probe both sides of the knee
        write_setting(REG_DRIVE, 16'hFFFF);
        send(16'sd3277);
        send(16'sd3276);
        send(-16'sd3277);
        send(-16'sd3276);
        drain();

        // tone extremes, level extremes and a write to the spare slot
        write_setting(REG_TONE, '0);
        send(16'sd12000);
        send(-16'sd20000);
        drain();
        write_setting(REG_TONE, CFG_ONE);
        send(16'sd12000);
        send(-16'sd20000);
        drain();
        write_setting(REG_LEVEL, '0);
        send(16'sd30000);
        drain();
        write_setting(REG_LEVEL, CFG_ONE);
        write_setting(REG_SPARE, 16'h1234);
        send(16'sd30000);
        send(-16'sd30000);
        drain();

        // random settings, each followed by a run of random samples
        for (int set_i = 0; set_i < RAND_SETS; set_i++)
        begin
            write_setting(REG_DRIVE, pick_setting());
            write_setting(REG_TONE, pick_setting());
            write_setting(REG_LEVEL, pick_setting());
            if ($urandom_range(3) == 0)
                write_setting(REG_SPARE, CFG_W'($urandom));
            steady = (set_i == 3);
            for (int k = 0; k < SET_BEATS; k++)
                send(pick_sample());
            drain();
        end
        steady = 1'b0;

        // final quiet window to catch stray beats
        repeat (40) @(posedge clk);

        $display("%0d samples sent, %0d results checked, %0d register writes",
                 sent_beats, checked_beats, setting_sets);
        $display("%0d samples clipped, %0d landed exactly on the unity point",
                 clipped_beats, unity_hits);
        if (errors == 0 && wet_expect_q.size() == 0)
            $display("overdrive_soft_clip_tone_core_tb: done, clean");
        else
            $display("overdrive_soft_clip_tone_core_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
